@@ hdl/frame_checksum_verifier_unit_defines.svh @@
// assertion macros shared by the checksum verifier modules
// expects clk and rst_n in the scope of each use
`ifndef FRAME_CHECKSUM_VERIFIER_UNIT_DEFINES_SVH
`define FRAME_CHECKSUM_VERIFIER_UNIT_DEFINES_SVH

// same-cycle implication
`define FCV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FCV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/fcv_pkg.sv @@
// shared types and constants for the frame checksum verifier
// no dependencies
package fcv_pkg;

  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned SUM_W          = 32;
  localparam int unsigned ACC_W          = 64;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [BYTE_W-1:0] COMMA_BYTE = 8'h2C;

  typedef struct packed {
    logic              fin;
    logic              add_en;
    logic              comma;
    logic              hex;
    logic [DIGIT_W-1:0] digit;
    logic [BYTE_W-1:0] data;
  } fcv_tok_t;

endpackage

@@ hdl/frame_checksum_verifier_unit.sv @@
// frame checksum verifier: one frame byte per item, one result per frame
// a terminator item passes through the queue, then its result is registered in the back-end result register
// throughput: one byte per cycle while in_stall is low; set by the per-byte add and hex shift in the back end
// a held result stalls the back end only on the next terminator, queue absorbs the rest
// reset: synchronous active-low rst_n clears the queue, frame state and output valid
// depends on fcv_pkg, fcv_front, fcv_queue, fcv_back
module frame_checksum_verifier_unit #(
  parameter int unsigned QUEUE_DEPTH = fcv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_is_final,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_match,
  output logic        out_status,
  output logic [31:0] out_computed_sum,
  output logic [31:0] out_received_value
);
  import fcv_pkg::*;

  fcv_tok_t push_tok;
  fcv_tok_t pop_tok;
  logic     push_valid;
  logic     q_full;
  logic     pop_valid;
  logic     pop_ready;

  fcv_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_frame_byte (in_frame_byte),
    .in_is_final   (in_is_final),
    .q_full        (q_full),
    .push_valid    (push_valid),
    .push_tok      (push_tok)
  );

  fcv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_tok   (push_tok),
    .full       (q_full),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_tok    (pop_tok)
  );

  fcv_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .tok_valid          (pop_valid),
    .tok                (pop_tok),
    .tok_ready          (pop_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_match          (out_match),
    .out_status         (out_status),
    .out_computed_sum   (out_computed_sum),
    .out_received_value (out_received_value)
  );

endmodule

@@ hdl/fcv_front.sv @@
// front end: classifies each incoming frame byte into a token
// depends on fcv_pkg
module fcv_front (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_frame_byte,
  input  logic                        in_is_final,
  input  logic                        q_full,
  output logic                        push_valid,
  output fcv_pkg::fcv_tok_t           push_tok
);
  import fcv_pkg::*;

  localparam logic [BYTE_W-1:0] DEC_LO   = 8'h30;
  localparam logic [BYTE_W-1:0] DEC_HI   = 8'h39;
  localparam logic [BYTE_W-1:0] LOW_LO   = 8'h61;
  localparam logic [BYTE_W-1:0] LOW_HI   = 8'h66;
  localparam logic [BYTE_W-1:0] UP_LO    = 8'h41;
  localparam logic [BYTE_W-1:0] UP_HI    = 8'h46;
  localparam logic [BYTE_W-1:0] ALPHA_OFS = 8'd10;

  logic [BYTE_W-1:0] dec_diff;
  logic [BYTE_W-1:0] low_diff;
  logic [BYTE_W-1:0] up_diff;
  logic              is_dec;
  logic              is_low;
  logic              is_up;
  logic              is_comma;

  assign in_stall   = q_full;
  assign push_valid = in_valid;

  always_comb begin
    dec_diff = in_frame_byte - DEC_LO;
    low_diff = in_frame_byte - LOW_LO + ALPHA_OFS;
    up_diff  = in_frame_byte - UP_LO + ALPHA_OFS;
    is_dec   = (in_frame_byte >= DEC_LO) && (in_frame_byte <= DEC_HI);
    is_low   = (in_frame_byte >= LOW_LO) && (in_frame_byte <= LOW_HI);
    is_up    = (in_frame_byte >= UP_LO) && (in_frame_byte <= UP_HI);
    is_comma = (in_frame_byte == COMMA_BYTE);

    push_tok.fin    = in_is_final;
    push_tok.add_en = !in_is_final || is_comma;
    push_tok.comma  = is_comma;
    push_tok.hex    = is_dec || is_low || is_up;
    push_tok.data   = in_frame_byte;
    priority if (is_dec) begin
      push_tok.digit = dec_diff[DIGIT_W-1:0];
    end else if (is_low) begin
      push_tok.digit = low_diff[DIGIT_W-1:0];
    end else begin
      push_tok.digit = up_diff[DIGIT_W-1:0];
    end
  end

endmodule

@@ hdl/fcv_queue.sv @@
// short token queue between front end and back end
// depends on fcv_pkg and the assertion macro header
`include "frame_checksum_verifier_unit_defines.svh"
module fcv_queue #(
  parameter int unsigned DEPTH = fcv_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  input  fcv_pkg::fcv_tok_t push_tok,
  output logic              full,
  output logic              pop_valid,
  input  logic              pop_ready,
  output fcv_pkg::fcv_tok_t pop_tok
);
  import fcv_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fcv_tok_t         mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             push;
  logic             pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign pop_valid = (cnt_r != '0);
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_ready;
  assign pop_tok   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  `FCV_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CNT_W'(DEPTH), "queue count above depth")
  `FCV_ASSERT_NEXT(a_cnt_drain, pop && !push, cnt_r == $past(cnt_r) - 1'b1, "queue drain miscount")

endmodule

@@ hdl/fcv_back.sv @@
// back end: running sum, comma snapshot, hex parse and result register
// depends on fcv_pkg and the assertion macro header
`include "frame_checksum_verifier_unit_defines.svh"
module fcv_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tok_valid,
  input  fcv_pkg::fcv_tok_t tok,
  output logic              tok_ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_match,
  output logic              out_status,
  output logic [31:0]       out_computed_sum,
  output logic [31:0]       out_received_value
);
  import fcv_pkg::*;

  logic [SUM_W-1:0] run_sum_r;
  logic [SUM_W-1:0] run_sum_nxt;
  logic [SUM_W-1:0] snap_r;
  logic [SUM_W-1:0] snap_nxt;
  logic             seen_r;
  logic             seen_nxt;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic             stop_r;
  logic             stop_nxt;
  logic [SUM_W-1:0] sext;
  logic             pop;
  logic             load;
  logic             out_valid_r;
  logic             out_match_r;
  logic             out_status_r;
  logic [SUM_W-1:0] out_sum_r;
  logic [SUM_W-1:0] out_recv_r;
  logic [SUM_W-1:0] computed;

  assign tok_ready = !tok.fin || !out_valid_r || !out_stall;
  assign pop       = tok_valid && tok_ready;
  assign load      = pop && tok.fin;

  always_comb begin
    sext        = {{(SUM_W-BYTE_W){tok.data[BYTE_W-1]}}, tok.data};
    run_sum_nxt = tok.add_en ? run_sum_r + sext : run_sum_r;
    snap_nxt    = snap_r;
    seen_nxt    = seen_r;
    acc_nxt     = acc_r;
    stop_nxt    = stop_r;
    if (tok.comma) begin
      snap_nxt = run_sum_nxt;
      seen_nxt = 1'b1;
      acc_nxt  = '0;
      stop_nxt = 1'b0;
    end else if (!tok.fin && !stop_r) begin
      priority if (!tok.hex) begin
        stop_nxt = 1'b1;
      end else if (acc_r[ACC_W-1 -: DIGIT_W] != '0) begin
        acc_nxt = '1;
      end else begin
        acc_nxt = {acc_r[ACC_W-DIGIT_W-1:0], tok.digit};
      end
    end
    computed = ~snap_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_sum_r   <= '0;
      snap_r      <= '0;
      seen_r      <= 1'b0;
      acc_r       <= '0;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        run_sum_r <= '0;
        snap_r    <= '0;
        seen_r    <= 1'b0;
        acc_r     <= '0;
        stop_r    <= 1'b0;
      end else if (pop) begin
        run_sum_r <= run_sum_nxt;
        snap_r    <= snap_nxt;
        seen_r    <= seen_nxt;
        acc_r     <= acc_nxt;
        stop_r    <= stop_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r <= !seen_nxt;
      out_match_r  <= seen_nxt && (computed == acc_nxt[SUM_W-1:0]);
      out_sum_r    <= seen_nxt ? computed : '0;
      out_recv_r   <= seen_nxt ? acc_nxt[SUM_W-1:0] : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_match          = out_match_r;
  assign out_status         = out_status_r;
  assign out_computed_sum   = out_sum_r;
  assign out_received_value = out_recv_r;

  `FCV_ASSERT_NEXT(a_frame_clear, load, (run_sum_r == '0) && !seen_r && (acc_r == '0) && !stop_r, "state not cleared after frame")
  `FCV_ASSERT_NOW(a_nocomma_zero, out_valid_r && out_status_r, !out_match_r && (out_sum_r == '0) && (out_recv_r == '0), "bad no-comma result")

endmodule
